// ----- hdl/kld_pkg.sv -----
// Shared types, constants and the log2 table for the KL divergence loss unit.
package kld_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int LOG_TABLE_DEPTH = 256;
    localparam int IDX_W           = $clog2(LOG_TABLE_DEPTH);
    localparam int FR_W            = 30 - IDX_W;
    localparam int LN_SHIFT        = 30 - FRAC_BITS;
    localparam int DIFF_W          = 36;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_REDUCTION_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE     = 1'd1;

    localparam logic [1:0] MODE_NONE      = 2'd0;
    localparam logic [1:0] MODE_SUM       = 2'd1;
    localparam logic [1:0] MODE_MEAN      = 2'd2;
    localparam logic [1:0] MODE_BATCHMEAN = 2'd3;

    localparam logic signed [39:0] LN2_Q30 = 40'sd744261118;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] batch;
    } kld_cfg_t;

    typedef struct packed {
        logic signed [63:0] term;
        logic               last;
    } kld_item_t;

    typedef logic [30:0] log_tab_t [0:LOG_TABLE_DEPTH];

    // log2 of a Q30 mantissa in [1,2) by repeated squaring
    function automatic logic [30:0] log2_q30(logic [63:0] m_in);
        logic [63:0] m;
        logic [30:0] y;
        m = m_in;
        y = '0;
        for (int k = 1; k <= 30; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                y[30-k] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t tab;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
            tab[i] = log2_q30((64'd1 << 30) + (64'(i) << FR_W));
        end
        tab[LOG_TABLE_DEPTH] = 31'd1 << 30;
        return tab;
    endfunction

    localparam log_tab_t LOG2_TAB = build_log_tab();

endpackage

// ----- hdl/kld_if.sv -----
// Stream and configuration channel interfaces of the KL divergence loss unit.
interface kld_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] log_prob_value;
    logic signed [31:0] target_value;
    logic               last_element;
    modport source (output valid, log_prob_value, target_value, last_element, input ready);
    modport sink   (input valid, log_prob_value, target_value, last_element, output ready);
endinterface

interface kld_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] loss_value;
    logic               last_result;
    modport source (output valid, loss_value, last_result, input ready);
    modport sink   (input valid, loss_value, last_result, output ready);
endinterface

interface kld_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kld_pkg::CFG_IDX_W-1:0]  index;
    logic [15:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/kld_front.sv -----
// Front pipeline: takes input pairs and forms the pointwise term.
module kld_front
(
    input  logic                clk,
    input  logic                rst_n,
    kld_in_if.sink              items,
    output kld_pkg::kld_item_t  push_item,
    output logic                push,
    input  logic                q_ready
);
    localparam int FR_W   = kld_pkg::FR_W;
    localparam int IDX_W  = kld_pkg::IDX_W;
    localparam int DIFF_W = kld_pkg::DIFF_W;

    logic [5:0] v_reg;
    logic       en;

    // stage A
    logic signed [31:0] a_x_reg, a_t_reg;
    logic               a_last_reg;
    // stage B
    logic signed [31:0] b_x_reg;
    logic [30:0]        b_t_reg;
    logic               b_last_reg, b_pos_reg;
    logic [4:0]         b_p_reg;
    // stage C
    logic signed [31:0] c_x_reg;
    logic [30:0]        c_t_reg, c_p0_reg;
    logic               c_last_reg, c_pos_reg;
    logic [4:0]         c_p_reg;
    logic [30+FR_W:0]   c_prod_reg;
    // stage D
    logic signed [31:0] d_x_reg;
    logic [30:0]        d_t_reg;
    logic               d_last_reg, d_pos_reg;
    logic [4:0]         d_p_reg;
    logic [61:0]        d_prod_reg;
    // stage E
    logic [30:0]        e_t_reg;
    logic               e_last_reg, e_pos_reg, e_neg_reg;
    logic [DIFF_W-1:0]  e_mag_reg;
    // stage F
    logic               f_last_reg, f_pos_reg, f_neg_reg;
    logic [DIFF_W+30:0] f_prod_reg;

    // leading one of the target
    logic [4:0] lead;
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 31; i++) begin
            if (a_t_reg[i]) lead = 5'(i);
        end
    end

    // normalize and look up
    logic [30:0]      norm;
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0]   idx_hi;
    logic [FR_W-1:0]  frac;
    logic [30:0]      tp0, tp1, dlt;
    always_comb
    begin
        norm   = b_t_reg << (5'd30 - b_p_reg);
        idx    = norm[29:FR_W];
        frac   = norm[FR_W-1:0];
        idx_hi = {1'b0, idx} + 1'b1;
        tp0    = kld_pkg::LOG2_TAB[idx];
        tp1    = kld_pkg::LOG2_TAB[idx_hi];
        dlt    = tp1 - tp0;
    end

    logic [30:0] l2;
    assign l2 = c_p0_reg + 31'(c_prod_reg >> FR_W);

    // exponent part, round ln to output fraction bits, subtract x
    logic signed [6:0]         ex;
    logic signed [39:0]        ln30, ln_q;
    logic signed [DIFF_W-1:0]  diff;
    always_comb
    begin
        ex   = $signed({2'b00, d_p_reg}) - 7'(kld_pkg::FRAC_BITS);
        ln30 = 40'(ex) * kld_pkg::LN2_Q30 + $signed({9'b0, d_prod_reg[60:30]});
        if (kld_pkg::LN_SHIFT > 0)
            ln_q = (ln30 + 40'(40'sd1 <<< (kld_pkg::LN_SHIFT - 1))) >>> kld_pkg::LN_SHIFT;
        else
            ln_q = ln30;
        diff = DIFF_W'(ln_q) - DIFF_W'(d_x_reg);
    end

    logic [DIFF_W+30:0] rnd;
    logic [63:0]        mag_r;
    always_comb
    begin
        rnd   = (f_prod_reg + ((DIFF_W+31)'(1) << (kld_pkg::FRAC_BITS - 1)))
                >> kld_pkg::FRAC_BITS;
        mag_r = 64'(rnd);
        push_item.last = f_last_reg;
        if (!f_pos_reg)
            push_item.term = '0;
        else if (f_neg_reg)
            push_item.term = -$signed(mag_r);
        else
            push_item.term = $signed(mag_r);
    end

    assign en          = !v_reg[5] || q_ready;
    assign push        = v_reg[5] && q_ready;
    assign items.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], items.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg    <= items.log_prob_value;
            a_t_reg    <= items.target_value;
            a_last_reg <= items.last_element;

            b_x_reg    <= a_x_reg;
            b_t_reg    <= a_t_reg[30:0];
            b_last_reg <= a_last_reg;
            b_pos_reg  <= !a_t_reg[31] && (a_t_reg[30:0] != '0);
            b_p_reg    <= lead;

            c_x_reg    <= b_x_reg;
            c_t_reg    <= b_t_reg;
            c_last_reg <= b_last_reg;
            c_pos_reg  <= b_pos_reg;
            c_p_reg    <= b_p_reg;
            c_p0_reg   <= tp0;
            c_prod_reg <= dlt * frac;

            d_x_reg    <= c_x_reg;
            d_t_reg    <= c_t_reg;
            d_last_reg <= c_last_reg;
            d_pos_reg  <= c_pos_reg;
            d_p_reg    <= c_p_reg;
            d_prod_reg <= 62'(l2) * 62'(kld_pkg::LN2_Q30[30:0]);

            e_t_reg    <= d_t_reg;
            e_last_reg <= d_last_reg;
            e_pos_reg  <= d_pos_reg;
            e_neg_reg  <= diff[DIFF_W-1];
            e_mag_reg  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

            f_last_reg <= e_last_reg;
            f_pos_reg  <= e_pos_reg;
            f_neg_reg  <= e_neg_reg;
            f_prod_reg <= (DIFF_W+31)'(e_mag_reg) * (DIFF_W+31)'(e_t_reg);
        end
    end
endmodule

// ----- hdl/kld_queue.sv -----
// Four-entry queue of terms between front and back.
module kld_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kld_pkg::kld_item_t push_item,
    output logic               push_ready,
    input  logic               pop,
    output kld_pkg::kld_item_t pop_item,
    output logic               pop_valid
);
    kld_pkg::kld_item_t mem_reg [0:3];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg;

    assign push_ready = (cnt_reg != 3'd4);
    assign pop_valid  = (cnt_reg != 3'd0);
    assign pop_item   = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= push_item;
    end
endmodule

// ----- hdl/kld_back.sv -----
// Back end: accumulation, reduction divide and output register.
module kld_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  kld_pkg::kld_cfg_t  cfg_state,
    input  kld_pkg::kld_item_t pop_item,
    input  logic               pop_valid,
    output logic               pop,
    kld_out_if.source          results
);
    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic [63:0]        dvd_reg, dvd_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic [5:0]         step_reg, step_next;
    logic               ov_reg, ov_next;
    logic signed [63:0] loss_reg, loss_next;
    logic               lastr_reg, lastr_next;

    logic               out_free;
    logic signed [64:0] sum_w;
    logic signed [63:0] sum_sat;
    logic [31:0]        cnt_inc, divisor;
    logic [32:0]        rem_sh;

    assign out_free = !ov_reg || results.ready;
    assign pop      = (state_reg == ST_ACC) && pop_valid && out_free;

    always_comb
    begin
        sum_w = {acc_reg[63], acc_reg} + {pop_item.term[63], pop_item.term};
        if (sum_w[64] != sum_w[63])
            sum_sat = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sum_sat = sum_w[63:0];
        cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        divisor = (cfg_state.mode == kld_pkg::MODE_MEAN) ? cnt_inc : 32'(cfg_state.batch);
        rem_sh  = {rem_reg[31:0], dvd_reg[63]};

        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        ov_next    = ov_reg && !results.ready;
        loss_next  = loss_reg;
        lastr_next = lastr_reg;

        unique case (state_reg)
            ST_ACC:
            begin
                if (pop)
                begin
                    if (cfg_state.mode == kld_pkg::MODE_NONE)
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        ov_next    = 1'b1;
                        loss_next  = pop_item.term;
                        lastr_next = pop_item.last;
                    end
                    else if (!pop_item.last)
                    begin
                        acc_next = sum_sat;
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (cfg_state.mode == kld_pkg::MODE_SUM || divisor == '0)
                        begin
                            ov_next    = 1'b1;
                            lastr_next = 1'b1;
                            loss_next  = (cfg_state.mode == kld_pkg::MODE_SUM) ? sum_sat : '0;
                        end
                        else
                        begin
                            neg_next   = sum_sat[63];
                            dvd_next   = sum_sat[63] ? 64'(-sum_sat) : 64'(sum_sat);
                            rem_next   = '0;
                            dvs_next   = divisor;
                            step_next  = '0;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_next = rem_sh - {1'b0, dvs_reg};
                    dvd_next = {dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    dvd_next = {dvd_reg[62:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == '1) state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    lastr_next = 1'b1;
                    loss_next  = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
        step_reg  <= step_next;
        loss_reg  <= loss_next;
        lastr_reg <= lastr_next;
    end

    assign results.valid       = ov_reg;
    assign results.loss_value  = loss_reg;
    assign results.last_result = lastr_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("divide started with zero divisor");
    a_none_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cfg_state.mode == kld_pkg::MODE_NONE) |=> (acc_reg == '0 && cnt_reg == '0))
        else $error("accumulator kept in per-element mode");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.last) |=> (acc_reg == '0 && cnt_reg == '0))
        else $error("accumulator not cleared after last element");
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (ov_reg && lastr_reg))
        else $error("reduction result not presented");
`endif
endmodule

// ----- hdl/kl_divergence_loss_unit.sv -----
// Top level of the KL divergence loss unit.
// Usage:
//   items   : input transactions {log_prob_value, target_value, last_element},
//             signed Q7.24; accepted when valid and ready are both high.
//   results : output transactions {loss_value (Q39.24), last_result}.
//   cfg     : register writes; index 0 reduction_mode, 1 batch_size.
//             Write only while the unit is idle.
// Throughput: one item per cycle through the six-stage front pipeline and
//   the four-entry queue while the queue has room. In mode none each item
//   gives its own result. In reduction modes non-final items give no
//   result; the final one gives the sum, or for mean and batchmean enters
//   a bit-serial divider whose signed quotient is the result (a zero batch
//   size gives a zero result without dividing); meanwhile the back end
//   takes no further terms (the front keeps filling the queue).
// Reset: mode none, batch size 1, accumulator and element count zero,
//   pipeline and queue empty.
// Stall: when results.ready is low the output register holds its
//   transaction; the queue then fills and items.ready drops.
module kl_divergence_loss_unit
(
    input  logic       clk,
    input  logic       rst_n,
    kld_in_if.sink     items,
    kld_out_if.source  results,
    kld_cfg_if.sink    cfg
);
    kld_pkg::kld_cfg_t  cfg_reg;
    kld_pkg::kld_item_t push_item, pop_item;
    logic               push, q_ready, pop, pop_valid;

    // configuration registers, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= kld_pkg::MODE_NONE;
            cfg_reg.batch <= 16'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                kld_pkg::REG_REDUCTION_MODE: cfg_reg.mode  <= cfg.data[1:0];
                kld_pkg::REG_BATCH_SIZE:     cfg_reg.batch <= cfg.data;
                default:                     cfg_reg       <= cfg_reg;
            endcase
        end
    end

    // term computation
    kld_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .push_item (push_item),
        .push      (push),
        .q_ready   (q_ready)
    );

    // decouples the front pipeline from the divider stalls
    kld_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid)
    );

    // accumulation, reduction and result register
    kld_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_reg),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop       (pop),
        .results   (results)
    );
endmodule
